FILE: rtl/core/min_cut_max_flow_core_macros.svh
// Assertion macros for the min cut core.
`ifndef MIN_CUT_MAX_FLOW_CORE_MACROS_SVH
`define MIN_CUT_MAX_FLOW_CORE_MACROS_SVH
`ifndef SYNTH
`define MCMF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MCMF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MCMF_ASSERT_IMP(label, clk, rstn, ante, cons)
`define MCMF_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/core/mcmf_pkg.sv
// Types and constants shared by the min cut core.
`default_nettype none
package mcmf_pkg;
    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 64;
    localparam int CAP_WIDTH = 24;
    localparam int NW = $clog2(MAX_NODES);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int FW = CAP_WIDTH + 1;
    localparam int RW = CAP_WIDTH + 2;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_ADD   = 2'd1;
    localparam logic [1:0] KIND_RUN   = 2'd2;

    localparam logic [0:0] REG_NODE_COUNT = 1'd0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  node_a;
        logic [5:0]  node_b;
        logic [23:0] capacity;
    } in_beat_t;

    typedef struct packed {
        logic [6:0]  edge_number;
        logic [6:0]  cut_count;
        logic [29:0] cut_total;
        logic        last;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLRF, ST_BFS_INIT, ST_BFS_POP, ST_BFS_RD, ST_BFS_EDGE,
        ST_NECK_RD, ST_NECK, ST_PUSH_RD, ST_PUSH, ST_SUM_RD, ST_SUM,
        ST_EMIT_RD, ST_EMIT, ST_OUT, ST_EMPTY
    } state_t;
endpackage
`default_nettype wire

FILE: rtl/core/min_cut_max_flow_core.sv
// Min cut core: edge table, breadth-first augmenting-path sequencer, cut emitter.
// A run clears all flows, then alternates a breadth-first search with pushing flow along
// each augmenting path found, until no path remains; it then sums the cut edges.
// One beat leaves per cut edge (or one empty beat), the last flagged; input waits while busy.
// aresetn (synchronous, active low) clears edge count, marks, pending beat, node_count=64.
`default_nettype none
`include "min_cut_max_flow_core_macros.svh"
module min_cut_max_flow_core import mcmf_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_beat_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_beat_t        m_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    state_t state_reg, state_next;
    logic [6:0] ncfg_reg;
    logic [EW:0] ecnt_reg, ecnt_next;
    logic [5:0] ea_mem [MAX_EDGES];
    logic [5:0] eb_mem [MAX_EDGES];
    logic [CAP_WIDTH-1:0] ec_mem [MAX_EDGES];
    logic signed [FW:0] fl_mem [MAX_EDGES];
    logic [MAX_NODES-1:0] vis_reg, vis_next;
    logic [EW-1:0] par_mem [MAX_NODES];
    logic [NW-1:0] q_mem [MAX_NODES];
    logic [NW:0] qh_reg, qh_next, qt_reg, qt_next;
    logic [NW-1:0] x_reg, x_next;
    logic [EW:0] e_reg, e_next;
    logic [5:0] rda, rdb;
    logic [CAP_WIDTH-1:0] rdc;
    logic signed [FW:0] rdf;
    logic [EW-1:0] pare;
    logic [NW-1:0] qx;
    logic signed [RW:0] neck_reg, neck_next;
    logic [NW:0] steps_reg, steps_next;
    logic [6:0] cnt_reg, cnt_next, k_reg, k_next;
    logic [29:0] tot_reg, tot_next;
    out_beat_t ob_reg, ob_next;
    logic ov_reg, ov_next;
    logic [NW-1:0] n1;
    logic [6:0] nact;
    logic signed [RW:0] room_fw, room_bw, room;
    logic usable, fwd, add_ok;
    logic fl_we, par_we, q_we;
    logic [EW-1:0] fl_wa, rd_e;
    logic signed [FW:0] fl_wd;
    logic [NW-1:0] q_wa, q_wd, par_wa;

    assign nact = (ncfg_reg < 7'd2) ? 7'd2 :
                  (ncfg_reg > 7'(MAX_NODES)) ? 7'(MAX_NODES) : ncfg_reg;
    assign n1 = NW'(nact - 7'd1);
    assign pready = 1'b1;
    assign prdata = {25'd0, ncfg_reg};
    assign s_ready = (state_reg == ST_IDLE) && !ov_reg;
    assign m_valid = ov_reg;
    assign m_data = ob_reg;
    assign add_ok = (7'(s_data.node_a) < nact) && (7'(s_data.node_b) < nact)
                    && ecnt_reg < (EW+1)'(MAX_EDGES);

    always_ff @(posedge aclk) begin
        if (!aresetn) ncfg_reg <= 7'd64;
        else if (psel && penable && pwrite && paddr == {REG_NODE_COUNT, 1'b0})
            ncfg_reg <= pwdata[6:0];
    end

    // memories
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && s_data.kind == KIND_ADD && add_ok) begin
            ea_mem[ecnt_reg[EW-1:0]] <= s_data.node_a;
            eb_mem[ecnt_reg[EW-1:0]] <= s_data.node_b;
            ec_mem[ecnt_reg[EW-1:0]] <= s_data.capacity;
        end
        rda <= ea_mem[rd_e];
        rdb <= eb_mem[rd_e];
        rdc <= ec_mem[rd_e];
    end
    always_ff @(posedge aclk) begin
        if (fl_we) fl_mem[fl_wa] <= fl_wd;
        rdf <= fl_mem[rd_e];
    end
    always_ff @(posedge aclk) begin
        if (par_we) par_mem[par_wa] <= e_reg[EW-1:0];
        pare <= par_mem[x_next];
    end
    always_ff @(posedge aclk) begin
        if (q_we) q_mem[q_wa] <= q_wd;
        qx <= q_mem[qh_reg[NW-1:0]];
    end

    // shared residual unit
    assign usable = (rda < nact[5:0] || nact == 7'd64) && (rdb < nact[5:0] || nact == 7'd64)
                    && rda != rdb;
    assign room_fw = $signed({2'b00, rdc}) - (RW+1)'(rdf);
    assign room_bw = $signed({2'b00, rdc}) + (RW+1)'(rdf);

    always_comb begin
        state_next = state_reg; ecnt_next = ecnt_reg; vis_next = vis_reg;
        qh_next = qh_reg; qt_next = qt_reg; x_next = x_reg; e_next = e_reg;
        neck_next = neck_reg; steps_next = steps_reg; cnt_next = cnt_reg;
        k_next = k_reg; tot_next = tot_reg; ob_next = ob_reg; ov_next = ov_reg;
        fl_we = 1'b0; fl_wa = e_reg[EW-1:0]; fl_wd = '0; par_we = 1'b0;
        par_wa = '0; q_we = 1'b0; q_wa = qt_reg[NW-1:0]; q_wd = '0;
        rd_e = e_reg[EW-1:0]; fwd = 1'b0; room = room_fw;
        if (ov_reg && m_ready) ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: if (s_valid && s_ready) begin
                case (s_data.kind)
                    KIND_CLEAR: ecnt_next = '0;
                    KIND_ADD: if (add_ok) ecnt_next = ecnt_reg + 1'b1;
                    KIND_RUN: begin e_next = '0; state_next = ST_CLRF; end
                    default: ;
                endcase
            end
            ST_CLRF: begin
                fl_we = 1'b1; fl_wd = '0; e_next = e_reg + 1'b1;
                if (e_reg == (EW+1)'(MAX_EDGES - 1)) state_next = ST_BFS_INIT;
            end
            ST_BFS_INIT: begin
                vis_next = '0; vis_next[0] = 1'b1; q_we = 1'b1; q_wa = '0; q_wd = '0;
                qh_next = '0; qt_next = (NW+1)'(1); state_next = ST_BFS_POP;
            end
            ST_BFS_POP: begin
                if (qh_reg == qt_reg) begin
                    if (vis_reg[n1]) begin
                        x_next = n1; neck_next = {1'b0, {RW{1'b1}}};
                        steps_next = '0; state_next = ST_NECK_RD;
                    end else begin
                        e_next = '0; cnt_next = '0; tot_next = '0; state_next = ST_SUM_RD;
                    end
                end else state_next = ST_BFS_RD;
            end
            ST_BFS_RD: begin
                // edge scan starts at entry 0
                rd_e = '0;
                x_next = qx; qh_next = qh_reg + 1'b1; e_next = '0;
                state_next = (ecnt_reg == '0) ? ST_BFS_POP : ST_BFS_EDGE;
            end
            ST_BFS_EDGE: begin
                // data for e_reg was read last cycle; prefetch next
                rd_e = EW'(e_reg + 1'b1);
                state_next = ST_BFS_EDGE;
                if (!e_reg[EW] && usable && (rda == x_reg || rdb == x_reg)) begin
                    fwd = (rda == x_reg);
                    room = fwd ? room_fw : room_bw;
                    if (room > 0 && !vis_reg[fwd ? rdb[NW-1:0] : rda[NW-1:0]]
                        && qt_reg < (NW+1)'(MAX_NODES)) begin
                        vis_next[fwd ? rdb[NW-1:0] : rda[NW-1:0]] = 1'b1;
                        par_we = 1'b1; par_wa = fwd ? rdb[NW-1:0] : rda[NW-1:0];
                        q_we = 1'b1; q_wd = par_wa; qt_next = qt_reg + 1'b1;
                    end
                end
                e_next = e_reg + 1'b1;
                if (e_reg + 1'b1 >= ecnt_reg) state_next = ST_BFS_POP;
            end
            ST_NECK_RD: begin
                rd_e = pare;
                state_next = (x_reg == '0 || steps_reg == (NW+1)'(MAX_NODES)) ?
                    ST_PUSH_RD : ST_NECK;
                if (state_next == ST_PUSH_RD) x_next = n1;
                if (state_next == ST_PUSH_RD) steps_next = '0;
            end
            ST_NECK: begin
                fwd = (rdb == x_reg);
                room = fwd ? room_fw : room_bw;
                if (room < neck_reg) neck_next = room;
                x_next = fwd ? rda[NW-1:0] : rdb[NW-1:0];
                steps_next = steps_reg + 1'b1; state_next = ST_NECK_RD;
                e_next = (EW+1)'(pare);
            end
            ST_PUSH_RD: begin
                rd_e = pare; e_next = (EW+1)'(pare);
                state_next = (x_reg == '0 || steps_reg == (NW+1)'(MAX_NODES)) ?
                    ST_BFS_INIT : ST_PUSH;
            end
            ST_PUSH: begin
                fwd = (rdb == x_reg);
                fl_we = 1'b1;
                fl_wd = fwd ? rdf + (FW+1)'(neck_reg) : rdf - (FW+1)'(neck_reg);
                x_next = fwd ? rda[NW-1:0] : rdb[NW-1:0];
                steps_next = steps_reg + 1'b1; state_next = ST_PUSH_RD;
            end
            ST_SUM_RD: begin
                rd_e = EW'(e_reg);
                state_next = (e_reg >= ecnt_reg) ? ST_EMIT_RD : ST_SUM;
                if (e_reg >= ecnt_reg) begin e_next = '0; k_next = '0; end
            end
            ST_SUM: begin
                if (usable && vis_reg[rda[NW-1:0]] != vis_reg[rdb[NW-1:0]]) begin
                    cnt_next = cnt_reg + 1'b1; tot_next = tot_reg + 30'(rdc);
                end
                e_next = e_reg + 1'b1; state_next = ST_SUM_RD;
            end
            ST_EMIT_RD: begin
                rd_e = EW'(e_reg);
                if (cnt_reg == '0) state_next = ST_EMPTY;
                else if (e_reg >= ecnt_reg) state_next = ST_IDLE;
                else state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (usable && vis_reg[rda[NW-1:0]] != vis_reg[rdb[NW-1:0]]) begin
                    k_next = k_reg + 1'b1; state_next = ST_OUT;
                end else state_next = ST_EMIT_RD;
                e_next = e_reg + 1'b1;
            end
            // e_reg and k_reg already point one past the cut edge
            ST_OUT: if (!ov_reg) begin
                ob_next.edge_number = e_reg;
                ob_next.cut_count = cnt_reg; ob_next.cut_total = tot_reg;
                ob_next.last = (k_reg == cnt_reg);
                ov_next = 1'b1; state_next = ST_EMIT_RD;
            end
            ST_EMPTY: if (!ov_reg) begin
                ob_next = '{edge_number: 7'd0, cut_count: 7'd0, cut_total: 30'd0, last: 1'b1};
                ov_next = 1'b1; state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; ecnt_reg <= '0; vis_reg <= '0; ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next; ecnt_reg <= ecnt_next; vis_reg <= vis_next;
            ov_reg <= ov_next;
        end
        qh_reg <= qh_next; qt_reg <= qt_next; x_reg <= x_next; e_reg <= e_next;
        neck_reg <= neck_next; steps_reg <= steps_next; cnt_reg <= cnt_next;
        k_reg <= k_next; tot_reg <= tot_next; ob_reg <= ob_next;
    end

    `MCMF_ASSERT_IMP(a_busy_not_ready, aclk, aresetn, state_reg != ST_IDLE, !s_ready)
    `MCMF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `MCMF_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_data))
    `MCMF_ASSERT_IMP(a_cnt_bound, aclk, aresetn, m_valid, m_data.cut_count <= 7'(MAX_EDGES))
endmodule
`default_nettype wire
